[rtl/ktd_pkg.sv]
// ----------------------------------------------------------------------------
// ktd_pkg
// Shared constants and types of the KLV triplet deframer.
// ----------------------------------------------------------------------------
package ktd_pkg;

  // Key length in bytes and the largest long-form length count.
  localparam int unsigned KEY_BYTES        = 16;
  localparam int unsigned MAX_LENGTH_BYTES = 8;

  localparam int unsigned KeyCntW = 5;  // holds 0 .. KEY_BYTES
  localparam int unsigned KeyW    = 128;

  // Phase tag carried with every result item.
  typedef enum logic [1:0] {
    KIND_KEY   = 2'd0,
    KIND_LEN   = 2'd1,
    KIND_VALUE = 2'd2
  } byte_kind_e;

endpackage

[rtl/klv_triplet_deframer.sv]
// ----------------------------------------------------------------------------
// klv_triplet_deframer
// Splits a byte stream of KLV packets (16-byte key, BER length, value).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one stream byte per item on stream_byte_i, handshaked by
//   in_valid_i / in_ready_o. Output channel: one result item per input item,
//   handshaked by out_valid_o / out_ready_i. Each result tags the byte as
//   key, length field or value; the byte that completes the length field
//   also carries the key, the decoded length and the size of the length
//   field. packet_end_o marks the last byte of a packet, length_error_o a
//   long-form count above eight (the parser then restarts on a key).
//   A byte accepted on the input sits in the input register and moves into
//   the result register, where out_valid_o rises, once that register is free.
//   Throughput is one byte per cycle while the receiver does not stall; the
//   per-byte decode is a single pass between the two registers.
//   Reset puts the parser at the start of a key and empties both registers.
//   When the receiver stalls, the result register holds; the input register
//   takes one more byte only if it is empty, and in_ready_o then drops.
// ----------------------------------------------------------------------------
module klv_triplet_deframer import ktd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  stream_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  byte_out_o,
  output logic [1:0]  byte_kind_o,
  output logic        header_done_o,
  output logic [63:0] key_high_o,
  output logic [63:0] key_low_o,
  output logic [63:0] value_length_o,
  output logic [3:0]  length_field_bytes_o,
  output logic        packet_end_o,
  output logic        length_error_o
);

  typedef enum logic [1:0] {
    PH_KEY       = 2'd0,
    PH_LEN_FIRST = 2'd1,
    PH_LEN_MORE  = 2'd2,
    PH_VALUE     = 2'd3
  } phase_e;

  // Input register.
  logic       in_vld_q;
  logic [7:0] in_byte_q;

  // Parser state.
  phase_e        phase_q, phase_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [3:0]    cnt_q, cnt_d;
  logic [63:0]   acc_q, acc_d;
  logic [63:0]   remain_q, remain_d;
  logic [3:0]    lsize_q, lsize_d;

  // Result register.
  logic        out_vld_q;
  logic [7:0]  res_byte_q;
  byte_kind_e  res_kind_q, res_kind_d;
  logic        res_hdr_q, res_hdr_d;
  logic [63:0] res_len_q, res_len_d;
  logic [3:0]  res_lsize_q, res_lsize_d;
  logic        res_end_q, res_end_d;
  logic        res_err_q, res_err_d;

  logic          out_free;
  logic          advance;
  logic [6:0]    ber_n;
  logic [KeyCntW-1:0] key_cnt_inc;
  logic [KeyW-1:0] key_base;
  logic [63:0]   hdr_len;
  logic [3:0]    hdr_size;
  logic          hdr_end;

  assign out_free   = !out_vld_q || out_ready_i;
  assign advance    = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || out_free;

  assign ber_n       = in_byte_q[6:0];
  assign key_cnt_inc = {1'b0, cnt_q} + KeyCntW'(1);
  assign key_base    = (cnt_q == '0) ? '0 : key_q;

  always_comb begin
    phase_d     = phase_q;
    key_d       = key_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    remain_d    = remain_q;
    lsize_d     = lsize_q;
    res_kind_d  = KIND_KEY;
    res_err_d   = 1'b0;
    res_end_d   = 1'b0;
    hdr_end     = 1'b0;
    hdr_len     = '0;
    hdr_size    = '0;

    case (phase_q)
      PH_KEY: begin
        key_d = {key_base[KeyW-9:0], in_byte_q};
        cnt_d = key_cnt_inc[3:0];
        if (key_cnt_inc >= KeyCntW'(KEY_BYTES)) begin
          cnt_d   = '0;
          phase_d = PH_LEN_FIRST;
        end
      end
      PH_LEN_FIRST: begin
        res_kind_d = KIND_LEN;
        if (!in_byte_q[7]) begin
          hdr_end  = 1'b1;
          hdr_len  = {57'd0, ber_n};
          hdr_size = 4'd1;
        end else if (ber_n > 7'(MAX_LENGTH_BYTES)) begin
          res_err_d = 1'b1;
          phase_d   = PH_KEY;
          cnt_d     = '0;
        end else if (ber_n == '0) begin
          hdr_end  = 1'b1;
          hdr_size = 4'd1;
        end else begin
          acc_d   = '0;
          cnt_d   = ber_n[3:0];
          lsize_d = ber_n[3:0] + 4'd1;
          phase_d = PH_LEN_MORE;
        end
      end
      PH_LEN_MORE: begin
        res_kind_d = KIND_LEN;
        acc_d      = {acc_q[55:0], in_byte_q};
        if (cnt_q != '0) begin
          cnt_d = cnt_q - 4'd1;
        end
        if (cnt_d == '0) begin
          hdr_end  = 1'b1;
          hdr_len  = acc_d;
          hdr_size = lsize_q;
        end
      end
      default: begin
        res_kind_d = KIND_VALUE;
        if (remain_q != '0) begin
          remain_d = remain_q - 64'd1;
        end
        if (remain_d == '0) begin
          res_end_d = 1'b1;
          phase_d   = PH_KEY;
          cnt_d     = '0;
        end
      end
    endcase

    // End of header: start the value, or close an empty packet.
    if (hdr_end) begin
      cnt_d = '0;
      if (hdr_len == '0) begin
        res_end_d = 1'b1;
        phase_d   = PH_KEY;
      end else begin
        remain_d = hdr_len;
        phase_d  = PH_VALUE;
      end
    end

    res_hdr_d   = hdr_end;
    res_len_d   = hdr_len;
    res_lsize_d = hdr_size;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      phase_q   <= PH_KEY;
      key_q     <= '0;
      cnt_q     <= '0;
      acc_q     <= '0;
      remain_q  <= '0;
      lsize_q   <= '0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
      if (advance) begin
        phase_q  <= phase_d;
        key_q    <= key_d;
        cnt_q    <= cnt_d;
        acc_q    <= acc_d;
        remain_q <= remain_d;
        lsize_q  <= lsize_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= stream_byte_i;
    end
    if (advance) begin
      res_byte_q  <= in_byte_q;
      res_kind_q  <= res_kind_d;
      res_hdr_q   <= res_hdr_d;
      res_len_q   <= res_len_d;
      res_lsize_q <= res_lsize_d;
      res_end_q   <= res_end_d;
      res_err_q   <= res_err_d;
    end
  end

  // The key register only changes on key bytes, so it still holds the key
  // of the current packet when the header completes.
  assign out_valid_o          = out_vld_q;
  assign byte_out_o           = res_byte_q;
  assign byte_kind_o          = res_kind_q;
  assign header_done_o        = res_hdr_q;
  assign key_high_o           = res_hdr_q ? key_q[KeyW-1:64] : '0;
  assign key_low_o            = res_hdr_q ? key_q[63:0] : '0;
  assign value_length_o       = res_len_q;
  assign length_field_bytes_o = res_lsize_q;
  assign packet_end_o         = res_end_q;
  assign length_error_o       = res_err_q;

endmodule

[rtl/ktd_checker.sv]
// ----------------------------------------------------------------------------
// ktd_checker
// Port-level checks of the KLV triplet deframer, bound to the top level.
// ----------------------------------------------------------------------------
module ktd_checker import ktd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  stream_byte_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  byte_out_o,
  input logic [1:0]  byte_kind_o,
  input logic        header_done_o,
  input logic [63:0] key_high_o,
  input logic [63:0] key_low_o,
  input logic [63:0] value_length_o,
  input logic [3:0]  length_field_bytes_o,
  input logic        packet_end_o,
  input logic        length_error_o
);

  // Only the length field can complete a header or fail.
  a_hdr_on_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (header_done_o || length_error_o) |-> byte_kind_o == KIND_LEN)
    else $error("header or error flag on a non-length byte");

  a_err_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && length_error_o |-> !header_done_o && !packet_end_o)
    else $error("length error together with header or packet end");

  // Header fields are zero outside the header's last byte.
  a_hdr_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !header_done_o |-> value_length_o == '0 &&
      length_field_bytes_o == '0 && key_high_o == '0 && key_low_o == '0)
    else $error("header fields set without header_done");

  // An empty value ends the packet on the header byte.
  a_empty_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && header_done_o && value_length_o == '0 |-> packet_end_o)
    else $error("empty packet without packet_end");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(byte_out_o))
    else $error("result item changed while stalled");

endmodule

bind klv_triplet_deframer ktd_checker u_ktd_checker (.*);
